### rtl/mrwt_pkg.sv
// Shared types for the Miller-Rabin witness test block.
package mrwt_pkg;

	// Classification of an item made by the front end.
	typedef enum logic [1:0] {
		CLS_PRIME     = 2'd0,
		CLS_COMPOSITE = 2'd1,
		CLS_TEST      = 2'd2
	} cls_t;

	// Verdict flags produced for every item.
	typedef struct packed {
		logic is_composite;
		logic base_tested;
	} verdict_t;

endpackage

### rtl/miller_rabin_witness_test_top.sv
// Top level of the Miller-Rabin witness test block.
//  channel | direction | handshake          | payload
//  in      | request   | in_valid/in_stall   | candidate, base
//  out     | result    | out_valid/out_stall | is_composite, base_tested
// A trivially decided request passes through the queue, then its verdict is registered.
// A tested request takes up to about (2*WORD_BITS) multiplies, done one at a time
// by the single shift-add modular multiplier in the back end.
// The base is first reduced modulo the candidate. One request is tested at a time.
// Reset clears control only; a two-entry queue holds requests while the back end works.
module miller_rabin_witness_test_top #(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [WORD_BITS-1:0] candidate,
	input  logic [WORD_BITS-1:0] base,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 is_composite,
	output logic                 base_tested
);

	logic                 q_valid;
	logic                 q_pop;
	mrwt_pkg::cls_t       q_cls;
	logic [WORD_BITS-1:0] q_candidate;
	logic [WORD_BITS-1:0] q_base;
	mrwt_pkg::verdict_t   verdict;

	mrwt_front #(.WORD_BITS(WORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.in_candidate(candidate), .in_base(base),
		.q_valid(q_valid), .q_pop(q_pop), .q_cls(q_cls),
		.q_candidate(q_candidate), .q_base(q_base)
	);

	mrwt_back #(.WORD_BITS(WORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_cls(q_cls),
		.q_candidate(q_candidate), .q_base(q_base),
		.out_valid(out_valid), .out_stall(out_stall), .out_verdict(verdict)
	);

	assign is_composite = verdict.is_composite;
	assign base_tested  = verdict.base_tested;

endmodule

### rtl/mrwt_front.sv
// Front end: accepts a request, classifies it and pushes it into a two-entry queue.
module mrwt_front #(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [WORD_BITS-1:0] in_candidate,
	input  logic [WORD_BITS-1:0] in_base,
	output logic                 q_valid,
	input  logic                 q_pop,
	output mrwt_pkg::cls_t       q_cls,
	output logic [WORD_BITS-1:0] q_candidate,
	output logic [WORD_BITS-1:0] q_base
);

	localparam logic [WORD_BITS-1:0] Two = WORD_BITS'(2);

	logic [1:0]           cnt_q;
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	mrwt_pkg::cls_t       cls_mem_q  [2];
	logic [WORD_BITS-1:0] cand_mem_q [2];
	logic [WORD_BITS-1:0] base_mem_q [2];
	mrwt_pkg::cls_t       cls_in;
	logic                 push;
	logic                 pop;

	always_comb begin
		if (in_candidate == Two) begin
			cls_in = mrwt_pkg::CLS_PRIME;
		end else if (!in_candidate[0] || in_candidate == WORD_BITS'(1)) begin
			cls_in = mrwt_pkg::CLS_COMPOSITE;
		end else begin
			cls_in = mrwt_pkg::CLS_TEST;
		end
	end

	assign in_stall    = (cnt_q == 2'd2);
	assign push        = in_valid && !in_stall;
	assign q_valid     = (cnt_q != 2'd0);
	assign pop         = q_pop && q_valid;
	assign q_cls       = cls_mem_q[rd_ptr_q];
	assign q_candidate = cand_mem_q[rd_ptr_q];
	assign q_base      = base_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cls_mem_q[wr_ptr_q]  <= cls_in;
			cand_mem_q[wr_ptr_q] <= in_candidate;
			base_mem_q[wr_ptr_q] <= in_base;
		end
	end

endmodule

### rtl/mrwt_back.sv
// Back end: runs the witness test with a bit-serial modular multiplier.
module mrwt_back #(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  mrwt_pkg::cls_t       q_cls,
	input  logic [WORD_BITS-1:0] q_candidate,
	input  logic [WORD_BITS-1:0] q_base,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mrwt_pkg::verdict_t   out_verdict
);

	localparam int CntBits = $clog2(WORD_BITS + 1);
	localparam logic [CntBits-1:0] WordCount = CntBits'(WORD_BITS);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_REDUCE = 8'b0000_0010,
		ST_SPLIT  = 8'b0000_0100,
		ST_PSTEP  = 8'b0000_1000,
		ST_MUL    = 8'b0001_0000,
		ST_PNEXT  = 8'b0010_0000,
		ST_SQCHK  = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		MUL_RES = 2'd0,
		MUL_SQ  = 2'd1,
		MUL_CUR = 2'd2
	} mul_op_t;

	state_t               state_q;
	mul_op_t              op_q;
	logic [WORD_BITS-1:0] n_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] e_q;
	logic [CntBits-1:0]   twos_q;
	logic [CntBits-1:0]   i_q;
	logic [WORD_BITS-1:0] res_q;
	logic [WORD_BITS-1:0] sq_q;
	logic [WORD_BITS-1:0] prev_q;
	logic [WORD_BITS-1:0] cur_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] addend_q;
	logic [WORD_BITS-1:0] mult_q;
	logic [CntBits-1:0]   red_q;
	logic                 valid_q;
	mrwt_pkg::verdict_t   verdict_q;

	logic [WORD_BITS:0]   acc_sum;
	logic [WORD_BITS-1:0] acc_next;
	logic [WORD_BITS:0]   dbl_sum;
	logic [WORD_BITS-1:0] dbl_next;
	logic [WORD_BITS:0]   red_sum;
	logic [WORD_BITS-1:0] red_next;
	logic [WORD_BITS-1:0] nm1;
	logic                 slot_free;

	// One modular add and one modular doubling per multiplier step.
	always_comb begin
		acc_sum  = {1'b0, acc_q} + {1'b0, addend_q};
		acc_next = (acc_sum >= {1'b0, n_q}) ? WORD_BITS'(acc_sum - {1'b0, n_q})
			: acc_sum[WORD_BITS-1:0];
		dbl_sum  = {addend_q, 1'b0};
		dbl_next = (dbl_sum >= {1'b0, n_q}) ? WORD_BITS'(dbl_sum - {1'b0, n_q})
			: dbl_sum[WORD_BITS-1:0];
		// Restoring reduction of the base, one bit a step, MSB first.
		red_sum  = {acc_q, a_q[WORD_BITS-1]};
		red_next = (red_sum >= {1'b0, n_q}) ? WORD_BITS'(red_sum - {1'b0, n_q})
			: red_sum[WORD_BITS-1:0];
	end

	assign nm1       = n_q - WORD_BITS'(1);
	assign slot_free = !valid_q || !out_stall;
	assign q_pop     = (state_q == ST_IDLE) && q_valid && slot_free;
	assign out_valid   = valid_q;
	assign out_verdict = verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (valid_q && !out_stall) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_cls == mrwt_pkg::CLS_TEST) begin
							state_q <= ST_REDUCE;
						end else begin
							valid_q <= 1'b1;
						end
					end
				end
				ST_REDUCE: begin
					if (red_q == WordCount) begin
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if (e_q[0]) begin
						state_q <= ST_PSTEP;
					end
				end
				ST_PSTEP: begin
					state_q <= (e_q == '0) ? ST_SQCHK : ST_MUL;
				end
				ST_MUL: begin
					if (mult_q == '0) begin
						state_q <= (op_q == MUL_CUR) ? ST_SQCHK : ST_PNEXT;
					end
				end
				ST_PNEXT: begin
					state_q <= ST_MUL;
				end
				ST_SQCHK: begin
					state_q <= ST_MUL;
					if (op_q == MUL_CUR) begin
						if (cur_q == WORD_BITS'(1) && prev_q != WORD_BITS'(1)
							&& prev_q != nm1) begin
							state_q <= ST_DONE;
						end else if (i_q + CntBits'(1) >= twos_q) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
						valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					n_q    <= q_candidate;
					a_q    <= q_base;
					e_q    <= q_candidate >> 1;
					twos_q <= CntBits'(1);
					acc_q  <= '0;
					red_q  <= '0;
					case (q_cls)
						mrwt_pkg::CLS_PRIME: begin
							verdict_q <= '{is_composite: 1'b0, base_tested: 1'b0};
						end
						mrwt_pkg::CLS_COMPOSITE: begin
							verdict_q <= '{is_composite: 1'b1, base_tested: 1'b0};
						end
						default: begin
							verdict_q <= '{is_composite: 1'b0, base_tested: 1'b1};
						end
					endcase
				end
			end
			ST_REDUCE: begin
				if (red_q != WordCount) begin
					acc_q <= red_next;
					a_q   <= a_q << 1;
					red_q <= red_q + CntBits'(1);
				end else begin
					sq_q  <= acc_q;
					res_q <= WORD_BITS'(1);
				end
			end
			ST_SPLIT: begin
				if (!e_q[0]) begin
					e_q    <= e_q >> 1;
					twos_q <= twos_q + CntBits'(1);
				end
			end
			ST_PSTEP: begin
				acc_q <= '0;
				if (e_q == '0) begin
					prev_q <= res_q;
					op_q   <= MUL_RES;
				end else if (e_q[0]) begin
					op_q     <= MUL_RES;
					addend_q <= sq_q;
					mult_q   <= res_q;
				end else begin
					op_q     <= MUL_SQ;
					addend_q <= sq_q;
					mult_q   <= sq_q;
				end
			end
			ST_MUL: begin
				if (mult_q != '0) begin
					if (mult_q[0]) begin
						acc_q <= acc_next;
					end
					addend_q <= dbl_next;
					mult_q   <= mult_q >> 1;
				end else begin
					case (op_q)
						MUL_RES: res_q <= acc_q;
						MUL_SQ:  sq_q  <= acc_q;
						default: cur_q <= acc_q;
					endcase
				end
			end
			ST_PNEXT: begin
				// After the multiply into res, square sq; after squaring, step e.
				acc_q <= '0;
				if (op_q == MUL_RES) begin
					op_q     <= MUL_SQ;
					addend_q <= sq_q;
					mult_q   <= sq_q;
				end else begin
					e_q <= e_q >> 1;
					if ((e_q >> 1) == '0) begin
						// Power done: square it for the first check.
						op_q     <= MUL_CUR;
						prev_q   <= res_q;
						addend_q <= res_q;
						mult_q   <= res_q;
						i_q      <= '0;
					end else if (e_q[1]) begin
						op_q     <= MUL_RES;
						addend_q <= sq_q;
						mult_q   <= res_q;
					end else begin
						op_q     <= MUL_SQ;
						addend_q <= sq_q;
						mult_q   <= sq_q;
					end
				end
			end
			ST_SQCHK: begin
				acc_q <= '0;
				if (op_q == MUL_CUR) begin
					if (cur_q == WORD_BITS'(1) && prev_q != WORD_BITS'(1)
						&& prev_q != nm1) begin
						verdict_q.is_composite <= 1'b1;
					end else if (i_q + CntBits'(1) >= twos_q) begin
						verdict_q.is_composite <= (cur_q != WORD_BITS'(1));
					end else begin
						i_q      <= i_q + CntBits'(1);
						prev_q   <= cur_q;
						addend_q <= cur_q;
						mult_q   <= cur_q;
					end
				end else begin
					// No exponent bits were left: x is res, first square follows.
					op_q     <= MUL_CUR;
					prev_q   <= res_q;
					addend_q <= res_q;
					mult_q   <= res_q;
					i_q      <= '0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/mrwt_checker.sv
// Port-level checker for the Miller-Rabin witness test block and its bind.
module mrwt_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic is_composite,
	input logic base_tested
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(is_composite) && $stable(base_tested))
		else $error("stalled result changed");

	a_no_valid_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid during reset");

	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({is_composite, base_tested}))
		else $error("result flags unknown");

	a_in_stall_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(in_stall))
		else $error("input stall unknown");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("stalled request withdrawn");

endmodule

bind miller_rabin_witness_test_top mrwt_port_checker u_mrwt_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.is_composite(is_composite), .base_tested(base_tested)
);

### sim/mrwt_checker.sv
// Verdict checker for the Miller-Rabin witness test block.
`timescale 1ns / 100ps
module mrwt_checker #(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [WORD_BITS-1:0] candidate,
	input  logic [WORD_BITS-1:0] base,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 is_composite,
	input  logic                 base_tested,
	output int                   errors,
	output int                   pending,
	output int                   n_tested,
	output int                   n_found_composite
);

	typedef logic [WORD_BITS-1:0] word_t;

	mrwt_pkg::verdict_t verdicts_due[$];

	function automatic word_t prod_mod(word_t x, word_t y, word_t n);
		logic [2*WORD_BITS-1:0] p;
		p = {{WORD_BITS{1'b0}}, x} * {{WORD_BITS{1'b0}}, y};
		return word_t'(p % {{WORD_BITS{1'b0}}, n});
	endfunction

	function automatic word_t power_mod(word_t b, word_t e, word_t n);
		word_t r, s;
		r = 1 % n;
		s = b % n;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (e[i])
				r = prod_mod(r, s, n);
			s = prod_mod(s, s, n);
		end
		return r;
	endfunction

	function automatic mrwt_pkg::verdict_t predict_verdict(word_t n, word_t a);
		mrwt_pkg::verdict_t v;
		word_t odd, x, sq;
		int twos;
		if (n == 2) begin
			v.is_composite = 1'b0;
			v.base_tested = 1'b0;
			return v;
		end
		if (n < 2 || !n[0]) begin
			v.is_composite = 1'b1;
			v.base_tested = 1'b0;
			return v;
		end
		v.base_tested = 1'b1;
		odd = n - 1;
		twos = 0;
		while (!odd[0]) begin
			odd = odd >> 1;
			twos++;
		end
		x = power_mod(a, odd, n);
		// A square equal to one whose root is not +-1 proves compositeness.
		for (int i = 0; i < twos; i++) begin
			sq = prod_mod(x, x, n);
			if (sq == 1 && x != 1 && x != n - 1) begin
				v.is_composite = 1'b1;
				return v;
			end
			x = sq;
		end
		v.is_composite = (x != 1);
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mrwt_pkg::verdict_t want;
		if (!arst_n) begin
			verdicts_due.delete();
			errors = 0;
			n_tested = 0;
			n_found_composite = 0;
		end else begin
			if (in_valid && !in_stall)
				verdicts_due.push_back(predict_verdict(candidate, base));
			if (out_valid && !out_stall) begin
				if (verdicts_due.size() == 0) begin
					$error("Result with no request outstanding");
					errors++;
				end else begin
					want = verdicts_due.pop_front();
					if (is_composite !== want.is_composite) begin
						$error("is_composite: expected %0b, got %0b",
							want.is_composite, is_composite);
						errors++;
					end
					if (base_tested !== want.base_tested) begin
						$error("base_tested: expected %0b, got %0b",
							want.base_tested, base_tested);
						errors++;
					end
					if (want.base_tested) n_tested++;
					if (want.base_tested && want.is_composite) n_found_composite++;
				end
			end
		end
		pending = verdicts_due.size();
	end

endmodule

### sim/tb_top.sv
// Testbench top: stimulus, flow control and verdict for the witness test block.
`timescale 1ns / 100ps
module tb_top;

	localparam int WB = 64;
	localparam int STALL_LIMIT = 200000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [WB-1:0] candidate = '0;
	logic [WB-1:0] base = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic          is_composite;
	logic          base_tested;
	int            errors, pending, n_tested, n_found_composite;
	bit            long_hold = 1'b0;
	int            idle_cycles = 0;
	int            n_sent = 0;

	always #5 clk = ~clk;

	miller_rabin_witness_test_top #(.WORD_BITS(WB)) u_top (.*);

	mrwt_checker #(.WORD_BITS(WB)) u_chk (.*);

	// Receiver: short random stall patterns, plus one long hold-off on request.
	initial begin
		int run;
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (40000) @(posedge clk);
				long_hold = 1'b0;
			end
			run = $urandom_range(1, 12);
			case ($urandom_range(0, 2))
				0: begin
					out_stall <= 1'b0;
					repeat (run * 8) @(posedge clk);
				end
				1: repeat (run) begin
					out_stall <= 1'($urandom_range(0, 1));
					@(posedge clk);
				end
				default: begin
					out_stall <= 1'b1;
					repeat (run) @(posedge clk);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Offers one request and holds it until it is taken; keep_valid leaves valid up.
	task automatic offer(input logic [WB-1:0] n, input logic [WB-1:0] a, input bit keep_valid);
		in_valid <= 1'b1;
		candidate <= n;
		base <= a;
		do @(posedge clk); while (in_stall);
		n_sent++;
		if (!keep_valid)
			in_valid <= 1'b0;
	endtask

	function automatic logic [WB-1:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [WB-1:0] pick_candidate();
		logic [WB-1:0] primes[6] = '{64'hFFFFFFFFFFFFFFC5, 64'd4294967291, 64'd2147483647,
			64'd1000000007, 64'h7FFFFFFFFFFFFFE7, 64'd2305843009213693951};
		logic [WB-1:0] pseudo[6] = '{64'd561, 64'd1105, 64'd1729, 64'd41041,
			64'd3215031751, 64'd2047};
		case ($urandom_range(0, 9))
			0: return rand_word() & ~64'd1;
			1: return WB'($urandom_range(3, 5000)) | 64'd1;
			2, 3: return primes[$urandom_range(0, 5)];
			4: return pseudo[$urandom_range(0, 5)];
			default: return rand_word() | 64'd1;
		endcase
	endfunction

	function automatic logic [WB-1:0] pick_base(logic [WB-1:0] n);
		if (n > 3 && $urandom_range(0, 9) != 0)
			return 64'd2 + rand_word() % (n - 64'd3);
		return rand_word();
	endfunction

	initial begin
		logic [WB-1:0] n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Trivial verdicts, then tested ones: extreme bases, a reducible base,
		// a nontrivial square root of one, and a strong pseudoprime.
		offer(64'd0, 64'd5, 0);
		offer(64'd1, '1, 0);
		offer(64'd2, 64'd0, 0);
		offer(64'd4, 64'd3, 0);
		offer(64'hFFFFFFFFFFFFFFFE, '1, 0);
		offer(64'd3, 64'd2, 0);
		offer(64'hFFFFFFFFFFFFFFC5, 64'd2, 0);
		offer(64'hFFFFFFFFFFFFFFC5, 64'hFFFFFFFFFFFFFFC4, 0);
		offer(64'd561, 64'd2, 0);
		offer(64'd2047, 64'd2, 0);
		offer(64'd97, 64'd0, 0);
		offer(64'd97, 64'd97, 0);
		offer(64'd97, 64'd1, 0);
		offer(64'd97, 64'd96, 0);
		offer(64'd97, '1, 0);
		offer('1, 64'd2, 0);
		offer('1, 64'hAAAAAAAAAAAAAAAA, 0);
		offer(64'd9, 64'd8, 0);

		// Long receiver hold-off while requests keep coming.
		long_hold = 1'b1;
		for (int i = 0; i < 6; i++) begin
			n = pick_candidate();
			offer(n, pick_base(n), i < 5);
		end

		for (int burst = 0; n_sent < 100; burst++) begin
			int len;
			len = $urandom_range(1, 6);
			for (int j = 0; j < len; j++) begin
				n = pick_candidate();
				offer(n, pick_base(n), j < len - 1);
			end
			if (burst == 5)
				wait (pending == 0);
			repeat ($urandom_range(0, 40)) @(posedge clk);
		end

		wait (pending == 0);
		repeat (200) @(posedge clk);
		$display("Sent %0d requests; %0d ran the witness test, %0d of those found composite.",
			n_sent, n_tested, n_found_composite);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
rtl/mrwt_pkg.sv
rtl/mrwt_front.sv
rtl/mrwt_back.sv
rtl/miller_rabin_witness_test_top.sv
rtl/mrwt_checker.sv
sim/mrwt_checker.sv
sim/tb_top.sv
